FILE: hw/rtl/mcms_pkg.sv
// ----------------------------------------------------------------------------
// mcms_pkg
// types and constants shared by the common-mode subtraction block
// ----------------------------------------------------------------------------
package mcms_pkg;

  localparam int unsigned MaxGroup  = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [5:0]  StuckOnes = 6'h3F;
  localparam logic [5:0]  StuckZero = 6'h00;
  localparam logic [11:0] AdcMin    = 12'd10;
  localparam logic [15:0] PedMin    = 16'd160;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSkipStuck  = 2'd0,
    CfgSkipTicks  = 2'd1,
    CfgTickLow    = 2'd2,
    CfgTickHigh   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] adc_sample;
    logic [15:0] pedestal_q4;
    logic [15:0] tick_index;
    logic        group_last;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] corrected_sample;
    logic               out_last;
  } out_item_t;

  // front to back: one classified item
  typedef struct packed {
    logic [11:0]        adc;
    logic signed [16:0] delta;
    logic               counted;
    logic               stuck;
    logic [15:0]        tick;
    logic               last;
  } cls_item_t;

  function automatic logic is_stuck(input logic [11:0] adc);
    return (adc[5:0] == StuckZero) || (adc[5:0] == StuckOnes);
  endfunction

endpackage

FILE: hw/rtl/mcms_front.sv
// ----------------------------------------------------------------------------
// mcms_front
// classifies incoming items and hands them on through a short queue
// ----------------------------------------------------------------------------
module mcms_front
  import mcms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_item_i,
  output logic      full_o,
  input  logic      skip_stuck_i,
  output logic      cls_valid_o,
  output cls_item_t cls_item_o,
  input  logic      cls_take_i
);

  localparam int unsigned Depth = 4;

  cls_item_t   fifo_q [Depth];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  cls_item_t   cls;
  logic        acc, take;

  assign full_o      = (cnt_q == 3'(Depth));
  assign acc         = push_i && !full_o;
  assign cls_valid_o = (cnt_q != 3'd0);
  assign take        = cls_take_i && cls_valid_o;
  assign cls_item_o  = fifo_q[rd_q];

  always_comb begin
    cls.adc     = in_item_i.adc_sample;
    cls.delta   = $signed({1'b0, in_item_i.adc_sample, 4'b0}) -
                  $signed({1'b0, in_item_i.pedestal_q4});
    cls.stuck   = skip_stuck_i && is_stuck(in_item_i.adc_sample);
    cls.counted = !cls.stuck && (in_item_i.adc_sample >= AdcMin) &&
                  (in_item_i.pedestal_q4 >= PedMin);
    cls.tick    = in_item_i.tick_index;
    cls.last    = in_item_i.group_last;
  end

  // group starts are tracked by the back from its fill count
  always_comb begin
    wr_d = wr_q; rd_d = rd_q; cnt_d = cnt_q;
    if (acc) wr_d = wr_q + 2'd1;
    if (take) rd_d = rd_q + 2'd1;
    cnt_d = cnt_q + 3'(acc) - 3'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) fifo_q[wr_q] <= cls;
  end

endmodule

FILE: hw/rtl/mcms_back.sv
// ----------------------------------------------------------------------------
// mcms_back
// stores a group, finds its median by rank counting and emits the results
// ----------------------------------------------------------------------------
module mcms_back
  import mcms_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MaxGroup
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cls_valid_i,
  input  cls_item_t   cls_item_i,
  output logic        cls_take_o,
  input  logic        skip_stuck_i,
  input  logic        skip_ticks_i,
  input  logic [15:0] tick_low_i,
  input  logic [15:0] tick_high_i,
  output logic        empty_o,
  output out_item_t   out_item_o,
  input  logic        pop_i
);

  localparam int unsigned IdxW = $clog2(MAX_GROUP);
  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);

  typedef enum logic [5:0] {
    StLoad   = 6'b000001,
    StCount  = 6'b000010,
    StRank   = 6'b000100,
    StRankJ  = 6'b001000,
    StEmit   = 6'b010000,
    StWait   = 6'b100000
  } state_e;

  state_e             st_q, st_d;
  logic [11:0]        samp_mem [MAX_GROUP];
  logic signed [16:0] delt_mem [MAX_GROUP];
  logic [MAX_GROUP-1:0] valid_q, valid_d;
  logic [CntW-1:0]    n_q, n_d, nv_q, nv_d;
  logic [CntW-1:0]    i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [15:0]        tick_q, tick_d;
  logic signed [18:0] corr_q, corr_d;
  logic [1:0]         hits_q, hits_d;
  logic signed [16:0] di_q, dj_q;
  logic [11:0]        sa_q;
  logic               rd_ok_q;
  logic               obuf_v_q, obuf_v_d;
  out_item_t          obuf_q, obuf_d;
  logic               wr_en, close, grp_first;
  logic [IdxW-1:0]    wr_idx, rd_idx;
  logic [CntW-1:0]    lo_r, hi_r;
  logic               window;
  logic signed [19:0] diff;
  logic signed [19:0] quo;

  assign empty_o    = !obuf_v_q;
  assign out_item_o = obuf_q;
  assign cls_take_o = (st_q == StLoad) && cls_valid_i;
  assign wr_en      = cls_take_o;
  assign grp_first  = (n_q == '0);
  assign wr_idx     = IdxW'(n_q);
  assign close      = cls_item_i.last || (n_q == CntW'(MAX_GROUP - 1)) ;

  // middle ranks: odd count uses one rank twice
  assign hi_r   = nv_q >> 1;
  assign lo_r   = nv_q[0] ? hi_r : hi_r - CntW'(1);
  assign window = skip_ticks_i && (tick_q > tick_low_i) && (tick_q < tick_high_i);
  assign diff   = $signed({3'b0, sa_q, 5'b0}) - 20'(corr_q);
  assign quo    = (diff < 0) ? -((-diff) >>> 5) : (diff >>> 5);

  always_comb begin
    rd_idx = IdxW'(i_q);
    if (st_q == StRankJ) rd_idx = IdxW'(j_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      samp_mem[wr_idx] <= cls_item_i.adc;
      delt_mem[wr_idx] <= cls_item_i.delta;
    end
    di_q <= delt_mem[IdxW'(i_q)];
    dj_q <= delt_mem[rd_idx];
    sa_q <= samp_mem[IdxW'(i_q)];
  end

  always_comb begin
    st_d = st_q; valid_d = valid_q; n_d = n_q; nv_d = nv_q;
    i_d = i_q; j_d = j_q; rank_d = rank_q; tick_d = tick_q;
    corr_d = corr_q; hits_d = hits_q;
    obuf_v_d = obuf_v_q && !pop_i; obuf_d = obuf_q;
    unique case (st_q)
      StLoad: if (cls_valid_i) begin
        if (grp_first) begin
          tick_d = cls_item_i.tick;
          valid_d = '0;
        end
        valid_d[wr_idx] = cls_item_i.counted;
        n_d = CntW'(wr_idx) + CntW'(1);
        if (close) begin
          st_d = StCount; i_d = '0; nv_d = '0;
        end
      end
      StCount: begin
        nv_d = nv_q + CntW'(valid_q[IdxW'(i_q)]);
        i_d = i_q + CntW'(1);
        if (i_d == n_q) begin
          st_d = StRank; i_d = '0; corr_d = '0; hits_d = '0;
        end
      end
      StRank: begin
        if (nv_q < CntW'(2) || i_q == n_q || hits_q == 2'd2) begin
          if (nv_q < CntW'(2)) corr_d = '0;
          st_d = StEmit; i_d = '0;
        end else if (!valid_q[IdxW'(i_q)]) begin
          i_d = i_q + CntW'(1);
        end else begin
          st_d = StRankJ; j_d = '0; rank_d = '0;
        end
      end
      StRankJ: begin
        // dj_q is registered, so it holds the entry for j_q - 1: j_q indexes the read just issued
        if (j_q != '0 && valid_q[IdxW'(j_q - CntW'(1))] &&
            (dj_q < di_q || (dj_q == di_q && (j_q - CntW'(1)) < i_q)))
          rank_d = rank_q + CntW'(1);
        j_d = j_q + CntW'(1);
        if (j_q == n_q) begin
          if (rank_d == lo_r) begin
            corr_d = corr_d + 19'(di_q); hits_d = hits_d + 2'd1;
          end
          if (rank_d == hi_r) begin
            corr_d = corr_d + 19'(di_q); hits_d = hits_d + 2'd1;
          end
          i_d = i_q + CntW'(1);
          st_d = StRank;
        end
      end
      StEmit: if (!obuf_v_d && rd_ok_q) begin
        obuf_v_d = 1'b1;
        obuf_d.corrected_sample = ((skip_stuck_i && is_stuck(sa_q)) || window)
                                  ? $signed({2'b0, sa_q}) : 14'(quo);
        obuf_d.out_last = (i_q + CntW'(1) == n_q);
        i_d = i_q + CntW'(1);
        if (obuf_d.out_last) begin
          st_d = StLoad;
          n_d = '0;
        end else begin
          st_d = StWait;
        end
      end
      StWait: st_d = StEmit;
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; valid_q <= '0; n_q <= '0; nv_q <= '0; i_q <= '0;
      j_q <= '0; rank_q <= '0; tick_q <= '0; corr_q <= '0; hits_q <= '0;
      obuf_v_q <= 1'b0; rd_ok_q <= 1'b0;
    end else begin
      st_q <= st_d; valid_q <= valid_d; n_q <= n_d; nv_q <= nv_d; i_q <= i_d;
      j_q <= j_d; rank_q <= rank_d; tick_q <= tick_d; corr_q <= corr_d;
      hits_q <= hits_d; obuf_v_q <= obuf_v_d;
      // sample read for index i is registered and valid in the cycle after i settles
      rd_ok_q <= (st_q == StEmit || st_q == StWait) && (i_d == i_q);
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

endmodule

FILE: hw/rtl/median_common_mode_subtract.sv
// ----------------------------------------------------------------------------
// median_common_mode_subtract
// median common-mode subtraction over one channel group per tick
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// input    in         push_i / full_o     in_item_i  (in_item_t)
// result   out        empty_o / pop_i     out_item_o (out_item_t)
// config   in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// loading takes an item whenever one is queued; after the last item of a
// group the back counts valid entries, ranks counted entries against all
// stored ones until both middle ranks are found, then emits the corrected
// items one at a time through a one-entry output buffer, alternating emit and
// wait states. reset clears all control state; stores need no clearing. the
// four-entry queue takes up to four items while the back is busy.
module median_common_mode_subtract
  import mcms_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MaxGroup
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  in_item_t            in_item_i,
  output logic                full_o,
  output logic                empty_o,
  output out_item_t           out_item_o,
  input  logic                pop_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        skip_stuck_q, skip_ticks_q;
  logic [15:0] tick_low_q, tick_high_q;
  logic        cls_valid, cls_take;
  cls_item_t   cls_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_stuck_q <= 1'b1; skip_ticks_q <= 1'b0;
      tick_low_q <= '0; tick_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSkipStuck: skip_stuck_q <= cfg_data_i[0];
        CfgSkipTicks: skip_ticks_q <= cfg_data_i[0];
        CfgTickLow:   tick_low_q   <= cfg_data_i;
        CfgTickHigh:  tick_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcms_front u_front (
    .clk_i, .rst_ni, .push_i, .in_item_i, .full_o,
    .skip_stuck_i (skip_stuck_q),
    .cls_valid_o  (cls_valid),
    .cls_item_o   (cls_item),
    .cls_take_i   (cls_take)
  );

  mcms_back #(.MAX_GROUP(MAX_GROUP)) u_back (
    .clk_i, .rst_ni,
    .cls_valid_i  (cls_valid),
    .cls_item_i   (cls_item),
    .cls_take_o   (cls_take),
    .skip_stuck_i (skip_stuck_q),
    .skip_ticks_i (skip_ticks_q),
    .tick_low_i   (tick_low_q),
    .tick_high_i  (tick_high_q),
    .empty_o, .out_item_o, .pop_i
  );

endmodule

FILE: tb/sv/median_common_mode_subtract_test.sv
// ----------------------------------------------------------------------------
// median_common_mode_subtract_test
// self-checking bench for the median common-mode subtraction block
// ----------------------------------------------------------------------------
// a directed table runs first, then a skip-window sweep, then random channel
// groups under several register settings. a built-in predictor works out the
// corrected samples of each group, and every popped item is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module median_common_mode_subtract_test
  import mcms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GroupMax = 64;
  localparam int unsigned CycleLimit = 2000000;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  in_item_t            in_item_i;
  logic                full_o;
  logic                empty_o;
  out_item_t           out_item_o;
  logic                pop_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  median_common_mode_subtract u_dut (.*);

  // predictor copy of the registers and of the group store
  logic        skip_stuck;
  logic        skip_ticks;
  logic [15:0] tick_low;
  logic [15:0] tick_high;
  logic [11:0]        adc_store [GroupMax];
  logic signed [16:0] delta_store [GroupMax];
  logic [GroupMax-1:0] counted_mask;
  int unsigned         stored;
  logic [15:0]         latched_tick;

  out_item_t   corrected_q[$];
  int unsigned fail_count;
  int unsigned cycle_count;

  // directed table row: item plus optional typed-in expectation
  typedef struct {
    in_item_t   item;
    logic       has_exp;
    logic signed [13:0] exp_sample;
  } row_t;
  row_t table_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  function automatic logic stuck_code(input logic [11:0] adc);
    return (adc[5:0] == StuckZero) || (adc[5:0] == StuckOnes);
  endfunction

  // delta of unique rank r among counted entries, ties broken by index
  function automatic int ranked_delta(input int unsigned n, input int unsigned r);
    int unsigned rank;
    for (int i = 0; i < n; i++) begin
      if (!counted_mask[i]) continue;
      rank = 0;
      for (int j = 0; j < n; j++) begin
        if (!counted_mask[j]) continue;
        if (delta_store[j] < delta_store[i] || (delta_store[j] == delta_store[i] && j < i))
          rank++;
      end
      if (rank == r) return int'(delta_store[i]);
    end
    return 0;
  endfunction

  // store one item and, on group close, queue the corrected samples
  task automatic predict_group(input in_item_t it);
    int unsigned idx, nvalid, n;
    int          corr_q5, v;
    logic        window;
    out_item_t   o;
    if (stored == 0) latched_tick = it.tick_index;
    idx = (stored >= GroupMax) ? GroupMax - 1 : stored;
    adc_store[idx] = it.adc_sample;
    delta_store[idx] = $signed({1'b0, it.adc_sample, 4'b0}) - $signed({1'b0, it.pedestal_q4});
    if (!(skip_stuck && stuck_code(it.adc_sample)) && it.adc_sample >= AdcMin
        && it.pedestal_q4 >= PedMin)
      counted_mask[idx] = 1'b1;
    stored = idx + 1;
    if (!it.group_last && stored < GroupMax) return;
    n = stored;
    nvalid = 0;
    for (int i = 0; i < n; i++) nvalid += counted_mask[i];
    if (nvalid < 2) corr_q5 = 0;
    else if (nvalid % 2 == 0)
      corr_q5 = ranked_delta(n, nvalid / 2) + ranked_delta(n, nvalid / 2 - 1);
    else corr_q5 = 2 * ranked_delta(n, (nvalid - 1) / 2);
    window = skip_ticks && latched_tick > tick_low && latched_tick < tick_high;
    for (int i = 0; i < n; i++) begin
      if ((skip_stuck && stuck_code(adc_store[i])) || window) v = adc_store[i];
      else v = (int'(adc_store[i]) * 32 - corr_q5) / 32;
      o.corrected_sample = v[13:0];
      o.out_last = (i + 1 == n);
      corrected_q = {corrected_q, o};
    end
    counted_mask = '0;
    stored = 0;
  endtask

  // result side: random pop stalls, compare at the rising edge
  initial begin
    int unsigned wait_n;
    out_item_t   want;
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      pop_i = 1'b0;
      repeat (wait_n) @(negedge clk_i);
      pop_i = 1'b1;
      do @(posedge clk_i); while (empty_o);
      if (corrected_q.size() == 0) begin
        report("unexpected item", $signed(out_item_o.corrected_sample), 0);
      end else begin
        want = corrected_q.pop_front();
        if (out_item_o.corrected_sample !== want.corrected_sample)
          report("corrected_sample", $signed(out_item_o.corrected_sample),
                 $signed(want.corrected_sample));
        if (out_item_o.out_last !== want.out_last)
          report("out_last", out_item_o.out_last, want.out_last);
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgSkipStuck: skip_stuck = data[0];
      CfgSkipTicks: skip_ticks = data[0];
      CfgTickLow:   tick_low = data;
      CfgTickHigh:  tick_high = data;
      default: ;
    endcase
  endtask

  // push one item after a random gap, predicting on acceptance
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    repeat (gap) @(negedge clk_i);
    push_i = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (full_o);
    predict_group(it);
    @(negedge clk_i);
    push_i = 1'b0;
  endtask

  // wait for every expected item, then let the back settle before a write
  task automatic drain();
    while (corrected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(input logic [11:0] adc, input logic [15:0] ped,
                                         input logic [15:0] tick, input logic last);
    in_item_t it;
    it.adc_sample = adc;
    it.pedestal_q4 = ped;
    it.tick_index = tick;
    it.group_last = last;
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input logic has, input int want);
    row_t r;
    r.item = it;
    r.has_exp = has;
    r.exp_sample = want[13:0];
    table_rows = {table_rows, r};
  endtask

  // random group: mostly small, the odd one full or overflowing
  task automatic random_group(output int unsigned sent);
    int unsigned len;
    logic [15:0] tick;
    logic [11:0] adc;
    logic [15:0] ped;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    len = (sel == 0) ? GroupMax : (sel == 1) ? GroupMax + $urandom_range(1, 3)
        : $urandom_range(1, 9);
    tick = (sel < 10) ? $urandom_range(0, 12) : 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: adc = 12'($urandom);
        1: adc = {6'($urandom), ($urandom_range(0, 1) ? StuckOnes : StuckZero)};
        2: adc = 12'($urandom_range(0, 12));
        default: adc = 12'($urandom_range(1500, 2600));
      endcase
      case ($urandom_range(0, 4))
        0: ped = 16'($urandom);
        1: ped = 16'($urandom_range(150, 170));
        default: ped = 16'($urandom_range(20000, 40000));
      endcase
      send_item(make_item(adc, ped, $urandom_range(0, 1) ? tick : 16'($urandom),
                          i == len - 1));
    end
    sent = len;
  endtask

  initial begin
    int unsigned sent, total;
    out_item_t   e;
    rst_ni = 1'b0;
    push_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgSkipStuck;
    cfg_data_i = '0;
    cycle_count = 0;
    fail_count = 0;
    skip_stuck = 1'b1;
    skip_ticks = 1'b0;
    tick_low = '0;
    tick_high = '0;
    counted_mask = '0;
    stored = 0;
    latched_tick = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // lone item: nothing counted, no correction
    add_row(make_item(12'd4095, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1, 4095);
    // stuck zero passes raw with skipping on
    add_row(make_item(12'd0, 16'd0, 16'd0, 1'b1), 1'b1, 0);
    // two counted deltas, mean of the pair: 0 and 16 counts, so 8 off each
    add_row(make_item(12'd100, 16'd1600, 16'd5, 1'b0), 1'b0, 0);
    add_row(make_item(12'd116, 16'd1600, 16'd9, 1'b1), 1'b1, 108);
    // below the adc and pedestal floors, a stuck ones code, odd count
    add_row(make_item(12'd9, 16'd500, 16'd7, 1'b0), 1'b0, 0);
    add_row(make_item(12'd200, 16'd159, 16'd7, 1'b0), 1'b0, 0);
    add_row(make_item(12'h07F, 16'd300, 16'd7, 1'b0), 1'b0, 0);
    add_row(make_item(12'd10, 16'd160, 16'd7, 1'b0), 1'b0, 0);
    add_row(make_item(12'd4094, 16'd65535, 16'd7, 1'b0), 1'b0, 0);
    add_row(make_item(12'd300, 16'd0, 16'd7, 1'b0), 1'b0, 0);
    add_row(make_item(12'd2000, 16'd160, 16'd7, 1'b1), 1'b0, 0);
    foreach (table_rows[k]) begin
      send_item(table_rows[k].item);
      if (table_rows[k].has_exp) begin
        e = corrected_q[$];
        if (e.corrected_sample !== table_rows[k].exp_sample)
          report("table row", $signed(e.corrected_sample), $signed(table_rows[k].exp_sample));
      end
    end
    drain();

    // skip window at its edges, stuck skipping off
    write_reg(CfgSkipStuck, 16'd0);
    write_reg(CfgSkipTicks, 16'd1);
    write_reg(CfgTickLow, 16'd4);
    write_reg(CfgTickHigh, 16'd8);
    for (int t = 3; t <= 9; t++) begin
      send_item(make_item(12'd1000, 16'd200, 16'(t), 1'b0));
      send_item(make_item(12'd1040, 16'd200, 16'hFFFF, 1'b0));
      send_item(make_item(12'd0, 16'd200, 16'd0, 1'b1));
    end
    drain();

    // random phases under a spread of settings, extremes included
    total = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgSkipStuck, 16'd1);
          write_reg(CfgSkipTicks, 16'd0);
        end
        1: begin
          write_reg(CfgSkipTicks, 16'd1);
          write_reg(CfgTickLow, 16'd0);
          write_reg(CfgTickHigh, 16'hFFFF);
        end
        2: begin
          write_reg(CfgTickLow, 16'd8);
          write_reg(CfgTickHigh, 16'd3);
        end
        3: begin
          write_reg(CfgSkipStuck, 16'd0);
          write_reg(CfgTickLow, 16'd2);
          write_reg(CfgTickHigh, 16'd9);
        end
        4: write_reg(CfgSkipTicks, 16'd0);
        default: begin
          write_reg(CfgSkipStuck, 16'hFFFF);
          write_reg(CfgSkipTicks, 16'hFFFE);
          write_reg(CfgTickLow, 16'($urandom));
          write_reg(CfgTickHigh, 16'($urandom));
        end
      endcase
      while (total < (phase + 1) * 70) begin
        random_group(sent);
        total += sent;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mcms_pkg.sv
hw/rtl/mcms_front.sv
hw/rtl/mcms_back.sv
hw/rtl/median_common_mode_subtract.sv
tb/sv/median_common_mode_subtract_test.sv
